[sv/knock_rhythm_detector_core_macros.svh]
// Assertion macros shared by the knock rhythm detector modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef KNOCK_RHYTHM_DETECTOR_CORE_MACROS_SVH
`define KNOCK_RHYTHM_DETECTOR_CORE_MACROS_SVH
`ifndef SYNTH
`define KRD_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define KRD_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define KRD_ASSERT(name, prop)
`define KRD_ASSERT_NEVER(name, cond)
`endif
`endif

[sv/krd_pkg.sv]
// Types and constants for the knock rhythm detector.
// Used by krd_ctrl, krd_datapath and knock_rhythm_detector_core.
package krd_pkg;

    localparam int TIME_W     = 32;
    localparam int VAL_W      = 24;
    localparam int TOL_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int SCALE_W    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_HIGH    = 2'd2;

    localparam logic [VAL_W-1:0]   GAP_RESET      = 24'd10000000;
    localparam logic [TOL_W-1:0]   TOL_LOW_RESET  = 11'd950;
    localparam logic [TOL_W-1:0]   TOL_HIGH_RESET = 11'd1050;
    localparam logic [SCALE_W-1:0] PER_MILLE      = 10'd1000;

    // product widths for the per-mille bound checks
    localparam int LO_W    = TOL_W + VAL_W;
    localparam int HI_W    = TOL_W + 1 + VAL_W;
    localparam int SCALE_P = VAL_W + SCALE_W;

    typedef struct packed {
        logic capture;
        logic sum_clr;
        logic sum_acc;
        logic div_step;
        logic mul;
        logic chk_step;
        logic emit;
    } krd_cmd_t;

    typedef struct packed {
        logic full;
        logic idx_last;
        logic out_free;
    } krd_stat_t;

endpackage

[sv/krd_ctrl.sv]
// Sequencer for the knock rhythm detector: capture, sum, divide, check, emit.
// Depends on krd_pkg and the assertion macro header.
`include "knock_rhythm_detector_core_macros.svh"

module krd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  krd_pkg::krd_stat_t stat,
    output krd_pkg::krd_cmd_t  cmd
);
    import krd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.full)
                begin
                    cmd.sum_clr = 1'b1;
                    state_next  = S_SUM;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SUM:
            begin
                cmd.sum_acc = 1'b1;
                if (stat.idx_last)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.chk_step = 1'b1;
                if (stat.idx_last)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `KRD_ASSERT(a_accept_to_eval, in_valid && in_ready |=> state_reg == S_EVAL)
    `KRD_ASSERT(a_emit_when_free, cmd.emit |-> stat.out_free)
    `KRD_ASSERT(a_sum_then_div, state_reg == S_SUM && stat.idx_last |=> state_reg == S_DIV)
    `KRD_ASSERT_NEVER(a_capture_outside_idle, cmd.capture && state_reg != S_IDLE)

endmodule

[sv/krd_datapath.sv]
// Datapath for the knock rhythm detector: config registers, interval window,
// sum accumulator, reciprocal divide by WINDOW, bound check, output register.
// Depends on krd_pkg and the assertion macro header.
`include "knock_rhythm_detector_core_macros.svh"

module krd_datapath
#(
    parameter int WINDOW = 7
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [krd_pkg::TIME_W-1:0]          knock_time,
    input  logic                                cfg_valid,
    input  logic [krd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [krd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  krd_pkg::krd_cmd_t                   cmd,
    output krd_pkg::krd_stat_t                  stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                unlocked,
    output logic [krd_pkg::VAL_W-1:0]           average_interval,
    output logic [2:0]                          window_count
);
    import krd_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = VAL_W + $clog2(WINDOW);
    localparam int REC_SH = SUM_W + $clog2(WINDOW);

    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);
    // ceil(2^REC_SH / WINDOW): exact quotient for every SUM_W-bit sum
    localparam logic [SUM_W:0]    REC_K     =
        (SUM_W + 1)'(((64'd1 << REC_SH) + 64'(WINDOW - 1)) / 64'(WINDOW));

    logic [VAL_W-1:0]  gap_reg;
    logic [TOL_W-1:0]  tol_lo_reg;
    logic [TOL_W-1:0]  tol_hi_reg;

    logic [TIME_W-1:0] last_time_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  wr_ptr_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  quot_reg;
    logic              ok_reg;
    logic              out_valid_reg;

    logic [VAL_W-1:0]  win_mem [WINDOW];
    logic [VAL_W-1:0]  avg_reg;
    logic [LO_W-1:0]   lo_bound_reg;
    logic [HI_W-1:0]   hi_bound_reg;
    logic              unlocked_reg;
    logic [VAL_W-1:0]  avg_out_reg;
    logic [2:0]        count_out_reg;

    logic [TIME_W-1:0] interval;
    logic              timed_out;
    logic [VAL_W-1:0]  win_rd;
    logic [2*SUM_W:0]  recip_prod;
    logic [VAL_W-1:0]  div_q;
    logic [VAL_W-1:0]  avg_next;
    logic [TOL_W:0]    tol_hi_p1;
    logic [LO_W-1:0]   lo_bound_next;
    logic [HI_W-1:0]   hi_bound_next;
    logic [SCALE_P-1:0] scaled_num;
    logic              in_bounds;

    assign interval  = knock_time - last_time_reg;
    assign timed_out = interval > TIME_W'(gap_reg);
    assign win_rd    = win_mem[idx_reg];

    // divide the window sum by WINDOW with one reciprocal multiply
    assign recip_prod = quot_reg * REC_K;
    assign div_q      = recip_prod[REC_SH +: VAL_W];

    // scaled >= low  <=>  x*1000 >= low*avg
    // scaled <= high <=>  x*1000 <  (high+1)*avg
    assign avg_next      = quot_reg[VAL_W-1:0];
    assign tol_hi_p1     = {1'b0, tol_hi_reg} + 1'b1;
    assign lo_bound_next = tol_lo_reg * avg_next;
    assign hi_bound_next = tol_hi_p1 * avg_next;
    assign scaled_num    = win_rd * PER_MILLE;
    assign in_bounds     = (HI_W'(scaled_num) >= HI_W'(lo_bound_reg))
                        && (HI_W'(scaled_num) < hi_bound_reg);

    assign stat.full     = (count_reg == CNT_FULL);
    assign stat.idx_last = (idx_reg == IDX_LAST);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign unlocked         = unlocked_reg;
    assign average_interval = avg_out_reg;
    assign window_count     = count_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg    <= GAP_RESET;
            tol_lo_reg <= TOL_LOW_RESET;
            tol_hi_reg <= TOL_HIGH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GAP_TIMEOUT: gap_reg    <= cfg_data;
                CFG_TOL_LOW:     tol_lo_reg <= cfg_data[TOL_W-1:0];
                CFG_TOL_HIGH:    tol_hi_reg <= cfg_data[TOL_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            count_reg     <= '0;
            wr_ptr_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                last_time_reg <= knock_time;
                if (timed_out)
                begin
                    count_reg  <= '0;
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= (wr_ptr_reg == IDX_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    if (count_reg != CNT_FULL)
                        count_reg <= count_reg + 1'b1;
                end
            end

            if (cmd.sum_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.sum_acc || cmd.chk_step)
            begin
                idx_reg <= stat.idx_last ? '0 : idx_reg + 1'b1;
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && !timed_out)
            win_mem[wr_ptr_reg] <= interval[VAL_W-1:0];

        // the accumulator is replaced by the quotient after the sum pass
        if (cmd.sum_clr)
        begin
            quot_reg <= '0;
        end
        else if (cmd.sum_acc)
        begin
            quot_reg <= quot_reg + SUM_W'(win_rd);
        end
        else if (cmd.div_step)
        begin
            quot_reg <= SUM_W'(div_q);
        end

        if (cmd.mul)
        begin
            avg_reg      <= avg_next;
            lo_bound_reg <= lo_bound_next;
            hi_bound_reg <= hi_bound_next;
            ok_reg       <= 1'b1;
        end
        else if (cmd.chk_step)
        begin
            ok_reg <= ok_reg && in_bounds;
        end

        if (cmd.emit)
        begin
            unlocked_reg  <= stat.full && ok_reg && (avg_reg != '0);
            avg_out_reg   <= stat.full ? avg_reg : '0;
            count_out_reg <= 3'(count_reg);
        end
    end

    `KRD_ASSERT(a_count_bounded, count_reg <= CNT_FULL)
    `KRD_ASSERT(a_unlock_needs_avg, out_valid && unlocked |-> average_interval != '0)
    `KRD_ASSERT(a_short_window_zero, cmd.emit && !stat.full |=> average_interval == '0 && !unlocked)

endmodule

[sv/knock_rhythm_detector_core.sv]
// Knock rhythm detector, top level.
// Input channel: in_valid/in_ready with knock_time, a free-running 32-bit
// microsecond timestamp. Output channel: out_valid/out_ready with unlocked,
// average_interval and window_count, exactly one result beat per knock.
// Config channel: cfg_valid/cfg_ready (always ready) with cfg_index and
// cfg_data; index 0 gap timeout, 1 low tolerance, 2 high tolerance, others
// dropped. Write config only while no knock is in flight.
// Sequence: a knock that times out or leaves the window short goes from
// capture through evaluate straight to emit. With a full window the
// sequencer adds a sum pass over the window, one entry per cycle, then the
// reciprocal divide and the bound products, then a tolerance pass over the
// window, one entry per cycle, before emit.
// One knock is worked on at a time; the next beat is taken as soon as the
// result sits in the output register, even while it waits there.
// A stalled receiver holds the result; the sequencer then waits before
// writing the next one. Reset returns the config registers to their
// defaults, empties the window and zeroes the last timestamp.
module knock_rhythm_detector_core
#(
    parameter int WINDOW = 7
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [krd_pkg::TIME_W-1:0]      knock_time,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            unlocked,
    output logic [krd_pkg::VAL_W-1:0]       average_interval,
    output logic [2:0]                      window_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [krd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [krd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import krd_pkg::*;

    krd_cmd_t  cmd;
    krd_stat_t stat;

    assign cfg_ready = 1'b1;

    krd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    krd_datapath #(.WINDOW(WINDOW)) u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .knock_time       (knock_time),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .unlocked         (unlocked),
        .average_interval (average_interval),
        .window_count     (window_count)
    );

endmodule

[tb/tb_knock_rhythm_detector_core.sv]
// Self-checking testbench for knock_rhythm_detector_core.
// Drives knock beats and register writes, predicts each result beat and checks it.
// Depends on krd_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_knock_rhythm_detector_core;

    import krd_pkg::*;

    localparam int WINDOW_LEN = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic             unlocked;
        logic [VAL_W-1:0] average;
        logic [2:0]       held;
    } knock_verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [TIME_W-1:0]     knock_time = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  unlocked;
    logic [VAL_W-1:0]      average_interval;
    logic [2:0]            window_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    knock_rhythm_detector_core #(.WINDOW(WINDOW_LEN)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .knock_time       (knock_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .unlocked         (unlocked),
        .average_interval (average_interval),
        .window_count     (window_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #6 clk = ~clk;

    // stimulus and scoreboard state
    logic [TIME_W-1:0] pending_knocks[$];
    knock_verdict_t    verdicts_due[$];
    int unsigned       knocks_queued = 0;
    int unsigned       knocks_accepted = 0;
    int unsigned       mismatches = 0;
    logic              knock_taken = 1'b0;
    logic              cfg_taken = 1'b0;
    logic              hold_rx = 1'b0;
    int unsigned       send_idle_pct = 12;
    int unsigned       recv_idle_pct = 65;
    int unsigned       phase_no = 0;
    logic [TIME_W-1:0] gen_time = '0;

    // predictor copy of the block
    logic [TIME_W-1:0] last_seen = '0;
    logic [VAL_W-1:0]  intervals [WINDOW_LEN];
    int unsigned       held_count = 0;
    int unsigned       write_slot = 0;
    logic [VAL_W-1:0]  gap_cfg = GAP_RESET;
    logic [TOL_W-1:0]  lo_cfg = TOL_LOW_RESET;
    logic [TOL_W-1:0]  hi_cfg = TOL_HIGH_RESET;

    function automatic knock_verdict_t predict_knock(input logic [TIME_W-1:0] now);
        knock_verdict_t  v;
        logic [TIME_W-1:0] gap;
        logic [63:0]     total;
        logic [63:0]     mean;
        logic [63:0]     scaled;
        logic            in_tol;
        v = '0;
        gap = now - last_seen;
        last_seen = now;
        if (gap > {8'd0, gap_cfg})
        begin
            held_count = 0;
            write_slot = 0;
        end
        else
        begin
            intervals[write_slot] = gap[VAL_W-1:0];
            write_slot = (write_slot + 1) % WINDOW_LEN;
            if (held_count < WINDOW_LEN)
                held_count++;
            if (held_count == WINDOW_LEN)
            begin
                total = '0;
                for (int i = 0; i < WINDOW_LEN; i++)
                    total += {40'd0, intervals[i]};
                mean = total / WINDOW_LEN;
                // zero mean stays locked
                if (mean != 0)
                begin
                    in_tol = 1'b1;
                    for (int i = 0; i < WINDOW_LEN; i++)
                    begin
                        scaled = ({40'd0, intervals[i]} * {54'd0, PER_MILLE}) / mean;
                        if (scaled > {53'd0, hi_cfg} || scaled < {53'd0, lo_cfg})
                            in_tol = 1'b0;
                    end
                    v.unlocked = in_tol;
                end
                v.average = mean[VAL_W-1:0];
            end
        end
        v.held = held_count[2:0];
        return v;
    endfunction

    // sample handshakes, update predictor, check result beats
    always @(posedge clk)
    begin
        knock_verdict_t want;
        knock_taken <= rst_n && in_valid && in_ready;
        cfg_taken   <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected beat: unlocked=%0b avg=%0d count=%0d",
                                 $realtime, unlocked, average_interval, window_count);
                    mismatches++;
                end
                else
                begin
                    want = verdicts_due[0];
                    verdicts_due.delete(0);
                    if (want.unlocked !== unlocked || want.average !== average_interval ||
                        want.held !== window_count)
                    begin
                        if (mismatches < 10)
                            $display("%0t: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                                     $realtime, want.unlocked, want.average, want.held,
                                     unlocked, average_interval, window_count);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                verdicts_due.insert(verdicts_due.size(), predict_knock(knock_time));
                knocks_accepted++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAP_TIMEOUT: gap_cfg = cfg_data[VAL_W-1:0];
                    CFG_TOL_LOW:     lo_cfg  = cfg_data[TOL_W-1:0];
                    CFG_TOL_HIGH:    hi_cfg  = cfg_data[TOL_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // knock driver: hold the beat until taken, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !knock_taken))
        begin
            if (pending_knocks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                knock_time <= pending_knocks[0];
                pending_knocks.delete(0);
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
        out_ready <= rst_n && !hold_rx && ($urandom_range(0, 99) >= recv_idle_pct);

    // long receiver hold-off so the core backs up into its input
    initial
    begin
        wait (phase_no == 5);
        repeat (20) @(negedge clk);
        hold_rx <= 1'b1;
        repeat (300) @(negedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IDX_W'($urandom());
    endtask

    task automatic set_config(input logic [VAL_W-1:0] gap, input logic [TOL_W-1:0] lo,
                              input logic [TOL_W-1:0] hi);
        write_reg(CFG_GAP_TIMEOUT, gap);
        // unused upper bits carry junk
        write_reg(CFG_TOL_LOW, CFG_DATA_W'(($urandom() << TOL_W) | lo));
        write_reg(CFG_TOL_HIGH, CFG_DATA_W'(($urandom() << TOL_W) | hi));
    endtask

    task automatic push_knock(input logic [TIME_W-1:0] t);
        pending_knocks.insert(pending_knocks.size(), t);
        gen_time = t;
        knocks_queued++;
    endtask

    // mostly rhythm runs with jitter and the odd outlier, the rest noise
    task automatic add_random_knocks(input int n, input logic [VAL_W-1:0] gap);
        int                made;
        int                run;
        int                kind;
        logic [TIME_W-1:0] gap_lim;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] jit;
        logic [TIME_W-1:0] step;
        made = 0;
        gap_lim = {8'd0, gap};
        while (made < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                base = $urandom_range(1, gap_lim >> $urandom_range(0, 12));
                run = $urandom_range(7, 12);
                jit = base >> $urandom_range(4, 8);
                for (int k = 0; k < run; k++)
                begin
                    step = base - jit + $urandom_range(0, 2 * jit);
                    if ($urandom_range(0, 19) == 0)
                        step = $urandom_range(0, gap_lim);
                    if (step > gap_lim)
                        step = gap_lim;
                    push_knock(gen_time + step);
                end
                made += run;
            end
            else
            begin
                case (kind % 4)
                    0: push_knock($urandom());
                    1: push_knock(gen_time + gap_lim + 1 + $urandom_range(0, 1000));
                    2: push_knock(gen_time + gap_lim);
                    default: push_knock(gen_time + $urandom_range(0, 1));
                endcase
                made++;
            end
        end
    endtask

    // fill from the rising edge so the driver never races the queue
    task automatic run_knocks(input int unsigned phase, input int unsigned snd_pct,
                              input int unsigned rcv_pct, input int n,
                              input logic [VAL_W-1:0] gap);
        @(posedge clk);
        phase_no = phase;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        add_random_knocks(n, gap);
        @(negedge clk);
        while (knocks_accepted != knocks_queued || verdicts_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: zero mean, wrap, clean rhythm, outlier, timeout edge
        @(posedge clk);
        phase_no = 1;
        for (int i = 0; i < 7; i++)
            push_knock(32'd0);
        push_knock(32'hFFFF_FFFF);
        for (int i = 0; i < 7; i++)
            push_knock(gen_time + 32'd1_000_000);
        push_knock(gen_time + 32'd1_100_000);
        push_knock(gen_time + 32'd10_000_000);
        push_knock(gen_time + 32'd10_000_001);
        run_knocks(1, 12, 65, 140, GAP_RESET);

        // widest timeout, tolerance 0 to 2000, max intervals overflow the value width in the sum
        set_config(24'hFF_FFFF, 11'd0, 11'd2000);
        @(posedge clk);
        for (int i = 0; i < 7; i++)
            push_knock(gen_time + 32'h00FF_FFFF);
        run_knocks(2, 12, 65, 150, 24'hFF_FFFF);

        // low bound above high bound
        begin
            logic [VAL_W-1:0] g;
            g = VAL_W'($urandom_range(1000, 24'hFF_FFFF));
            set_config(g, 11'd2047, 11'd0);
            run_knocks(3, 65, 12, 140, g);
        end

        set_config(24'd1, TOL_LOW_RESET, TOL_HIGH_RESET);
        run_knocks(4, 65, 12, 120, 24'd1);

        begin
            logic [VAL_W-1:0] g;
            g = VAL_W'($urandom_range(20000, 3_000_000));
            set_config(g, TOL_W'($urandom_range(900, 1000)),
                       TOL_W'($urandom_range(1000, 1100)));
            run_knocks(5, 0, 0, 170, g);
        end

        begin
            logic [VAL_W-1:0] g;
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
            g = VAL_W'($urandom_range(1, 24'hFF_FFFF));
            set_config(g, 11'd1000, 11'd1000);
            run_knocks(6, 0, 0, 150, g);
        end

        set_config(GAP_RESET, 11'd980, 11'd1020);
        run_knocks(7, 0, 0, 150, GAP_RESET);

        repeat (60) @(negedge clk);
        if (verdicts_due.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
